[rtl/core/assert_macros.svh]
// Assertion helpers, clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge.
`define SCA_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition implies a property at the same edge.
`define SCA_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Condition implies a property at the next edge.
`define SCA_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/core/sca_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sca_pkg
// Shared constants and types of the step count to angle accumulator.
// ----------------------------------------------------------------------------
package sca_pkg;

    localparam int SPR_W      = 12;
    localparam int TOTAL_W    = 24;
    localparam int COUNT_W    = 32;
    localparam int WHOLE_W    = 32;
    localparam int MICRO_W    = 21;
    localparam int DIVIDEND_W = 32;
    localparam int DATA_IN_W  = 32;
    localparam int DATA_OUT_W = 56;

    localparam logic signed [32:0] TOTAL_MAX = 33'sd5965232;
    localparam logic signed [32:0] TOTAL_MIN = -33'sd5965232;
    localparam logic [31:0]        DEG_FULL  = 32'd360;
    localparam logic [31:0]        MICRO     = 32'd1000000;

    localparam logic REQ_REPORT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV1_GO,
        ST_DIV1_WAIT,
        ST_MUL,
        ST_DIV2_GO,
        ST_DIV2_WAIT,
        ST_DONE
    } state_t;

endpackage

[rtl/core/sca_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sca_div
// Radix-2 restoring divider, unsigned, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sca_div #(
    parameter int DIVIDEND_W = sca_pkg::DIVIDEND_W,
    parameter int DIVISOR_W  = sca_pkg::SPR_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder
);

    import sca_pkg::*;

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;

    logic [DIVISOR_W+1:0]  diff;
    logic                  ge;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVISOR_W:0]    shifted;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff     = {1'b0, shifted} - {2'b00, divisor};
        ge       = !diff[DIVISOR_W+1];
        rem_next = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    `SCA_ASSERT_IMP(a_done_idle, done_reg, !busy_reg, "divider done while busy")
    `SCA_ASSERT_IMP(a_rem_below, done_reg, rem_reg < divisor, "remainder not below divisor")
    `SCA_ASSERT_NEXT(a_start_busy, start, busy_reg, "divider did not start")

endmodule

[rtl/core/step_count_to_angle_accumulator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// step_count_to_angle_accumulator
// Signed step total with range-checked reports and angle readout.
// ----------------------------------------------------------------------------
// A report word (tuser 0) adds its signed count to the step total, or is
// dropped and flagged if the total would leave +-5965232; its result passes
// through ST_DONE into the output register. A read word (tuser 1) clears
// the total and returns whole degrees and millionths of a degree, both
// truncated toward zero, computed by one shared 32-step radix-2 divider
// run twice (total*360 / steps, then remainder*1000000 / steps). One word
// is worked on at a time; a finished result sits in the output register,
// so the next word can be taken while it waits. A steps_per_rev of 0
// divides by 1.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module step_count_to_angle_accumulator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [sca_pkg::SPR_W-1:0]      cfg_wr_data,   // steps_per_rev
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [sca_pkg::DATA_IN_W-1:0]  s_axis_tdata,  // report_count
    input  logic                           s_axis_tuser,  // req_type
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [sca_pkg::DATA_OUT_W-1:0] m_axis_tdata,  // whole_degrees, micro_degrees
    output logic                           m_axis_tuser   // dropped
);

    import sca_pkg::*;

    state_t state_reg, state_next;

    logic [SPR_W-1:0]          spr_reg;
    logic signed [TOTAL_W-1:0] total_reg;
    logic [SPR_W-1:0]          div_reg;
    logic                      neg_reg;
    logic [DIVIDEND_W-1:0]     mag_reg;
    logic                      res_drop_reg;
    logic [WHOLE_W-1:0]        res_whole_reg;
    logic [MICRO_W-1:0]        res_micro_reg;
    logic                      out_valid_reg;
    logic                      out_user_reg;
    logic [DATA_OUT_W-1:0]     out_data_reg;

    logic                      accept;
    logic                      div_start;
    logic                      out_load;
    logic                      div_done;
    logic [DIVIDEND_W-1:0]     div_quo;
    logic [SPR_W-1:0]          div_rem;

    logic signed [32:0]        sum;
    logic                      in_range;
    logic [TOTAL_W-1:0]        abs_total;
    logic [DIVIDEND_W-1:0]     scaled_mag;
    logic [DIVIDEND_W-1:0]     rem_scaled;

    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        sum        = {{(33 - TOTAL_W){total_reg[TOTAL_W-1]}}, total_reg}
                   + {s_axis_tdata[COUNT_W-1], s_axis_tdata};
        in_range   = (sum <= TOTAL_MAX) && (sum >= TOTAL_MIN);
        abs_total  = total_reg[TOTAL_W-1] ? TOTAL_W'(-total_reg) : TOTAL_W'(total_reg);
        scaled_mag = {{(DIVIDEND_W - TOTAL_W){1'b0}}, abs_total} * DEG_FULL;
        rem_scaled = {{(DIVIDEND_W - SPR_W){1'b0}}, div_rem} * MICRO;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (s_axis_tuser == REQ_READ) ? ST_DIV1_GO : ST_DONE;
                end
            end
            ST_DIV1_GO:   state_next = ST_DIV1_WAIT;
            ST_DIV1_WAIT: state_next = div_done ? ST_MUL : ST_DIV1_WAIT;
            ST_MUL:       state_next = ST_DIV2_GO;
            ST_DIV2_GO:   state_next = ST_DIV2_WAIT;
            ST_DIV2_WAIT: state_next = div_done ? ST_DONE : ST_DIV2_WAIT;
            ST_DONE:      state_next = out_load ? ST_IDLE : ST_DONE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:    s_axis_tready = 1'b1;
            ST_DIV1_GO: div_start     = 1'b1;
            ST_DIV2_GO: div_start     = 1'b1;
            ST_DONE:    out_load      = !out_valid_reg || m_axis_tready;
            default:    ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            spr_reg       <= SPR_W'(1);
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                spr_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                if (s_axis_tuser == REQ_READ)
                begin
                    total_reg <= '0;
                end
                else if (in_range)
                begin
                    total_reg <= sum[TOTAL_W-1:0];
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_drop_reg  <= (s_axis_tuser == REQ_REPORT) && !in_range;
            res_whole_reg <= '0;
            res_micro_reg <= '0;
            div_reg       <= (spr_reg == '0) ? SPR_W'(1) : spr_reg;
            neg_reg       <= total_reg[TOTAL_W-1];
            mag_reg       <= scaled_mag;
        end
        if (state_reg == ST_DIV1_WAIT && div_done)
        begin
            res_whole_reg <= neg_reg ? WHOLE_W'(-div_quo) : WHOLE_W'(div_quo);
        end
        if (state_reg == ST_MUL)
        begin
            mag_reg <= rem_scaled;
        end
        if (state_reg == ST_DIV2_WAIT && div_done)
        begin
            res_micro_reg <= neg_reg ? MICRO_W'(-div_quo[MICRO_W-1:0])
                                     : div_quo[MICRO_W-1:0];
        end
        if (out_load)
        begin
            out_user_reg <= res_drop_reg;
            out_data_reg <= {{(DATA_OUT_W - WHOLE_W - MICRO_W){1'b0}},
                             res_micro_reg, res_whole_reg};
        end
    end

    sca_div #(
        .DIVIDEND_W (DIVIDEND_W),
        .DIVISOR_W  (SPR_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag_reg),
        .divisor   (div_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tdata  = out_data_reg;

    `SCA_ASSERT(a_total_range,
                (total_reg <= 24'sd5965232) && (total_reg >= -24'sd5965232),
                "step total out of range")
    `SCA_ASSERT_NEXT(a_read_clears, accept && (s_axis_tuser == REQ_READ),
                     total_reg == '0, "read did not clear total")
    `SCA_ASSERT_IMP(a_drop_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0,
                    "dropped word carries an angle")
    `SCA_ASSERT_IMP(a_div_idle, div_done,
                    (state_reg == ST_DIV1_WAIT) || (state_reg == ST_DIV2_WAIT),
                    "divider done outside a wait state")

endmodule
